// File: hdl/pdr_pkg.sv
package pdr_pkg;

    // Rule codes reported with each result
    typedef enum logic [2:0] {
        RULE_STAKE      = 3'd0,
        RULE_NO_HISTORY = 3'd1,
        RULE_SLOW       = 3'd2,
        RULE_FAST       = 3'd3,
        RULE_RETARGET   = 3'd4,
        RULE_CLAMPED    = 3'd5
    } rule_t;

    // Control that travels with every beat through the chain
    typedef struct packed {
        logic        early;   // answer decided up front
        logic [31:0] word;    // early answer
        rule_t       rule;
        logic        shift;   // target pre-shifted near the limit
    } ctl_t;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SPACING  = 2'd0;
    localparam logic [1:0] REG_TIMESPAN = 2'd1;
    localparam logic [1:0] REG_WORK_LIM = 2'd2;
    localparam logic [1:0] REG_STAKE_LIM = 2'd3;

    localparam logic [15:0] SPACING_RST  = 16'd60;
    localparam logic [23:0] TIMESPAN_RST = 24'd86400;
    localparam logic [31:0] LIMIT_RST    = 32'h1E0F_FFFF;

    // Clamped timespan needs 26 bits, divisor 24 bits
    localparam int SPAN_W = 26;
    localparam int DIV_W  = 24;

    // x/3 for 16-bit x as (x*43691) >> 17
    localparam logic [16:0] THIRD_MUL   = 17'd43691;
    localparam int          THIRD_SHIFT = 17;

endpackage

// File: hdl/pdr_expand.sv
module pdr_expand #(
    parameter int W = 256
) (
    input  logic [31:0]  word,
    output logic [W-1:0] val
);

    logic [7:0]    size;
    logic [22:0]   mant;
    logic [W+22:0] wide;
    logic [10:0]   shl;
    logic [4:0]    shr;

    // Compact word to full-width integer
    always_comb
    begin
        size = word[31:24];
        mant = word[22:0];
        shr  = {~size[1:0], 3'b000};
        shl  = {size - 8'd3, 3'b000};
        wide = (W+23)'(mant) << shl;
        if (size <= 8'd3)
        begin
            val = W'(mant >> shr);
        end
        else
        begin
            val = wide[W-1:0];
        end
    end

endmodule

// File: hdl/pdr_blen.sv
module pdr_blen #(
    parameter int W = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [W-1:0]             val,
    output logic [$clog2(W+1)-1:0]   blen
);

    localparam int NL = (W + 31) / 32;
    localparam int BW = $clog2(W + 1);

    logic [NL*32-1:0] padded;
    logic [NL-1:0]    nz_reg;
    logic [NL-1:0]    nz_next;
    logic [4:0]       idx_reg  [NL];
    logic [4:0]       idx_next [NL];
    logic [BW-1:0]    blen_reg;
    logic [BW-1:0]    blen_next;

    assign padded = (NL*32)'(val);

    // Stage 1: top set bit inside each 32-bit limb
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            nz_next[l]  = |padded[32*l +: 32];
            idx_next[l] = 5'd0;
            for (int b = 0; b < 32; b++)
            begin
                if (padded[32*l + b])
                begin
                    idx_next[l] = 5'(b);
                end
            end
        end
    end

    // Stage 2: highest nonzero limb wins
    always_comb
    begin
        blen_next = '0;
        for (int l = 0; l < NL; l++)
        begin
            if (nz_reg[l])
            begin
                blen_next = BW'(32*l + int'(idx_reg[l]) + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nz_reg   <= nz_next;
            idx_reg  <= idx_next;
            blen_reg <= blen_next;
        end
    end

    assign blen = blen_reg;

endmodule

// File: hdl/pdr_front.sv
module pdr_front #(
    parameter int W = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      history_ready,
    input  logic                      stake_mode,
    input  logic [31:0]               new_block_time,
    input  logic [31:0]               last_block_time,
    input  logic [31:0]               first_block_time,
    input  logic [31:0]               last_target_word,
    input  logic [15:0]               target_spacing,
    input  logic [23:0]               target_timespan,
    input  logic [31:0]               work_limit_word,
    input  logic [31:0]               stake_limit_word,
    output logic                      out_valid,
    output pdr_pkg::ctl_t             out_ctl,
    output logic [pdr_pkg::SPAN_W-1:0] out_span,
    output logic [W-1:0]              out_t,
    output logic [$clog2(W+1)-1:0]    lim_blen
);

    localparam int BW = $clog2(W + 1);

    logic [33:0]         slow_bound;
    logic [32:0]         third_prod;
    logic [15:0]         third;
    logic                slow;
    logic                fast;
    logic signed [33:0]  diff;
    logic [21:0]         lo;
    logic [25:0]         hi;
    logic [pdr_pkg::SPAN_W-1:0] span_next;
    pdr_pkg::ctl_t       ctl_next;
    logic [W-1:0]        t_exp;
    logic [W-1:0]        lim;
    logic [BW-1:0]       t_blen;

    logic                v1_reg, v2_reg, v3_reg;
    pdr_pkg::ctl_t       ctl1_reg, ctl2_reg, ctl3_reg;
    logic [pdr_pkg::SPAN_W-1:0] span1_reg, span2_reg, span3_reg;
    logic [W-1:0]        t1_reg, t2_reg, t3_reg;
    logic                shift;

    pdr_expand #(.W(W)) u_exp_t (.word(last_target_word), .val(t_exp));
    pdr_expand #(.W(W)) u_exp_l (.word(work_limit_word), .val(lim));

    // Early rules and timespan clamp
    always_comb
    begin
        slow_bound = 34'(last_block_time) + 34'({target_spacing, 2'b00})
                   + 34'(target_spacing);
        slow       = 34'(new_block_time) > slow_bound;
        third_prod = 33'(target_spacing) * 33'(pdr_pkg::THIRD_MUL);
        third      = 16'(third_prod >> pdr_pkg::THIRD_SHIFT);
        fast       = 34'(new_block_time) < 34'(last_block_time) + 34'(third);

        ctl_next.early = 1'b1;
        ctl_next.shift = 1'b0;
        ctl_next.word  = '0;
        ctl_next.rule  = pdr_pkg::RULE_RETARGET;
        if (stake_mode)
        begin
            ctl_next.word = stake_limit_word;
            ctl_next.rule = pdr_pkg::RULE_STAKE;
        end
        else if (!history_ready)
        begin
            ctl_next.word = work_limit_word;
            ctl_next.rule = pdr_pkg::RULE_NO_HISTORY;
        end
        else if (slow)
        begin
            ctl_next.word = work_limit_word;
            ctl_next.rule = pdr_pkg::RULE_SLOW;
        end
        else if (fast)
        begin
            ctl_next.word = {1'b0, last_target_word[31:1]};
            ctl_next.rule = pdr_pkg::RULE_FAST;
        end
        else
        begin
            ctl_next.early = 1'b0;
        end

        diff = $signed({2'b00, last_block_time}) - $signed({2'b00, first_block_time});
        lo   = target_timespan[23:2];
        hi   = {target_timespan, 2'b00};
        if (diff < $signed({12'd0, lo}))
        begin
            span_next = 26'(lo);
        end
        else if (diff > $signed({8'd0, hi}))
        begin
            span_next = hi;
        end
        else
        begin
            span_next = diff[25:0];
        end
    end

    // Valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload pipe alongside the bit-length unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg  <= ctl_next;
            span1_reg <= span_next;
            t1_reg    <= t_exp;
            ctl2_reg  <= ctl1_reg;
            span2_reg <= span1_reg;
            t2_reg    <= t1_reg;
            ctl3_reg  <= ctl2_reg;
            span3_reg <= span2_reg;
            t3_reg    <= t2_reg;
        end
    end

    pdr_blen #(.W(W)) u_blen_t (.clk(clk), .en(en), .val(t1_reg), .blen(t_blen));
    pdr_blen #(.W(W)) u_blen_l (.clk(clk), .en(en), .val(lim), .blen(lim_blen));

    // Pre-shift when target is at least as long as the limit
    always_comb
    begin
        shift = (lim_blen != '0) && (t_blen >= lim_blen);
        out_ctl       = ctl3_reg;
        out_ctl.shift = shift;
        out_t         = shift ? (t3_reg >> 1) : t3_reg;
    end

    assign out_valid = v3_reg;
    assign out_span  = span3_reg;

endmodule

// File: hdl/pdr_mul_cell.sv
module pdr_mul_cell #(
    parameter int NL = 8,
    parameter int K  = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  pdr_pkg::ctl_t              in_ctl,
    input  logic [pdr_pkg::SPAN_W-1:0] in_span,
    input  logic [NL*32-1:0]           in_vec,
    input  logic [pdr_pkg::SPAN_W-1:0] in_carry,
    output logic                       out_valid,
    output pdr_pkg::ctl_t              out_ctl,
    output logic [pdr_pkg::SPAN_W-1:0] out_span,
    output logic [NL*32-1:0]           out_vec,
    output logic [pdr_pkg::SPAN_W-1:0] out_carry
);

    localparam int PW = 32 + pdr_pkg::SPAN_W;

    logic [PW-1:0]              prod;
    logic [NL*32-1:0]           vec_next;
    logic                       valid_reg;
    pdr_pkg::ctl_t              ctl_reg;
    logic [pdr_pkg::SPAN_W-1:0] span_reg;
    logic [NL*32-1:0]           vec_reg;
    logic [pdr_pkg::SPAN_W-1:0] carry_reg;

    // One limb times span, limb replaced in place by the product limb
    always_comb
    begin
        prod = PW'(in_vec[32*K +: 32]) * PW'(in_span) + PW'(in_carry);
        vec_next = in_vec;
        vec_next[32*K +: 32] = prod[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= in_ctl;
            span_reg  <= in_span;
            vec_reg   <= vec_next;
            carry_reg <= prod[PW-1:32];
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_span  = span_reg;
    assign out_vec   = vec_reg;
    assign out_carry = carry_reg;

endmodule

// File: hdl/pdr_div_cell.sv
module pdr_div_cell #(
    parameter int W = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [pdr_pkg::DIV_W-1:0] divisor,
    input  logic                      in_valid,
    input  pdr_pkg::ctl_t             in_ctl,
    input  logic [W-1:0]              in_vec,
    input  logic [pdr_pkg::DIV_W-1:0] in_rem,
    output logic                      out_valid,
    output pdr_pkg::ctl_t             out_ctl,
    output logic [W-1:0]              out_vec,
    output logic [pdr_pkg::DIV_W-1:0] out_rem
);

    logic [pdr_pkg::DIV_W:0]   r2;
    logic                      ge;
    logic [pdr_pkg::DIV_W:0]   diff;
    logic                      valid_reg;
    pdr_pkg::ctl_t             ctl_reg;
    logic [W-1:0]              vec_reg;
    logic [pdr_pkg::DIV_W-1:0] rem_reg;

    // One restoring step: dividend MSB out, quotient bit in
    always_comb
    begin
        r2   = {in_rem, in_vec[W-1]};
        ge   = r2 >= {1'b0, divisor};
        diff = r2 - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            vec_reg <= {in_vec[W-2:0], ge};
            rem_reg <= ge ? diff[pdr_pkg::DIV_W-1:0] : r2[pdr_pkg::DIV_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_vec   = vec_reg;
    assign out_rem   = rem_reg;

endmodule

// File: hdl/pdr_back.sv
module pdr_back #(
    parameter int W = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  pdr_pkg::ctl_t             in_ctl,
    input  logic [W-1:0]              in_q,
    input  logic [23:0]               target_timespan,
    input  logic [31:0]               work_limit_word,
    input  logic [$clog2(W+1)-1:0]    lim_blen,
    output logic                      out_valid,
    output logic [31:0]               next_target_word,
    output logic [2:0]                rule_taken
);

    localparam int BW = $clog2(W + 1);

    logic [W-1:0]   v_next;
    logic [W-1:0]   lim;
    logic [BW-1:0]  v_blen;
    logic           use_lim;

    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    pdr_pkg::ctl_t  ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [W-1:0]   val1_reg, val2_reg, val3_reg, val4_reg;
    logic [BW-1:0]  blen4_reg;
    pdr_pkg::ctl_t  ctl4_next;

    logic [8:0]     size;
    logic [11:0]    shr;
    logic [31:0]    c32;
    logic [23:0]    c24;
    logic [31:0]    word_next;

    logic           out_valid_reg;
    logic [31:0]    word_reg;
    pdr_pkg::rule_t rule_reg;

    pdr_expand #(.W(W)) u_exp_l (.word(work_limit_word), .val(lim));

    // Undo the pre-shift; zero timespan gives a zero quotient
    always_comb
    begin
        if (target_timespan == 24'd0)
        begin
            v_next = '0;
        end
        else if (in_ctl.shift)
        begin
            v_next = in_q << 1;
        end
        else
        begin
            v_next = in_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    pdr_blen #(.W(W)) u_blen_v (.clk(clk), .en(en), .val(val1_reg), .blen(v_blen));

    // Clamp against the limit; early answers keep their own rule
    always_comb
    begin
        use_lim   = (val3_reg == '0) || (val3_reg > lim);
        ctl4_next = ctl3_reg;
        if (!ctl3_reg.early)
        begin
            ctl4_next.rule = use_lim ? pdr_pkg::RULE_CLAMPED : pdr_pkg::RULE_RETARGET;
        end
    end

    // Pack into compact form
    always_comb
    begin
        size = 9'((12'(blen4_reg) + 12'd7) >> 3);
        shr  = {size - 9'd3, 3'b000};
        if (size <= 9'd3)
        begin
            c32 = val4_reg[31:0] << {~size[1:0], 3'b000};
        end
        else
        begin
            c32 = 32'(val4_reg >> shr);
        end
        c24 = c32[23:0];
        if (c24[23])
        begin
            c24  = c24 >> 8;
            size = size + 9'd1;
        end
        word_next = {size[7:0], c24};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg  <= in_ctl;
            val1_reg  <= v_next;
            ctl2_reg  <= ctl1_reg;
            val2_reg  <= val1_reg;
            ctl3_reg  <= ctl2_reg;
            val3_reg  <= val2_reg;
            ctl4_reg  <= ctl4_next;
            val4_reg  <= use_lim ? lim : val3_reg;
            blen4_reg <= use_lim ? lim_blen : v_blen;
            word_reg  <= ctl4_reg.early ? ctl4_reg.word : word_next;
            rule_reg  <= ctl4_reg.rule;
        end
    end

    assign out_valid        = out_valid_reg;
    assign next_target_word = word_reg;
    assign rule_taken       = 3'(rule_reg);

endmodule

// File: hdl/pow_difficulty_retarget.sv
// Difficulty retarget engine.
// Input channel: in_valid / in_stall with the request fields (block times,
// previous compact target word, stake and history flags). A beat is taken
// when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with next_target_word and
// rule_taken, held steady while out_stall is high.
// Configuration: APB write/read of spacing, timespan and the two limit
// words at byte addresses 0, 4, 8, 12. pready is tied high.
// The pipeline is three front stages (decode, bit-length tree), one
// multiply-by-span cell per 32-bit limb, one restoring divide cell per
// quotient bit, four back stages and the output register.
// Throughput is one beat per cycle while no result is held by out_stall;
// every cell advances together.
// While a result sits in the output register with out_stall high the whole
// chain freezes and in_stall is raised; otherwise a new beat is taken even
// while a result is waiting.
// Reset clears all valid flags and loads the configuration defaults.
module pow_difficulty_retarget #(
    parameter int TARGET_BITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        history_ready,
    input  logic        stake_mode,
    input  logic [31:0] new_block_time,
    input  logic [31:0] last_block_time,
    input  logic [31:0] first_block_time,
    input  logic [31:0] last_target_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_target_word,
    output logic [2:0]  rule_taken,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W  = TARGET_BITS;
    localparam int NL = (W + 31) / 32;
    localparam int BW = $clog2(W + 1);
    localparam int SW = pdr_pkg::SPAN_W;
    localparam int DW = pdr_pkg::DIV_W;

    logic [15:0] spacing_reg;
    logic [23:0] timespan_reg;
    logic [31:0] work_lim_reg;
    logic [31:0] stake_lim_reg;
    logic        wr;
    logic        en;

    logic [W-1:0]     front_t;
    logic [BW-1:0]    lim_blen;

    logic             mul_valid [NL+1];
    pdr_pkg::ctl_t    mul_ctl   [NL+1];
    logic [SW-1:0]    mul_span  [NL+1];
    logic [NL*32-1:0] mul_vec   [NL+1];
    logic [SW-1:0]    mul_carry [NL+1];

    logic             div_valid [W+1];
    pdr_pkg::ctl_t    div_ctl   [W+1];
    logic [W-1:0]     div_vec   [W+1];
    logic [DW-1:0]    div_rem   [W+1];

    // Configuration registers
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= pdr_pkg::SPACING_RST;
            timespan_reg  <= pdr_pkg::TIMESPAN_RST;
            work_lim_reg  <= pdr_pkg::LIMIT_RST;
            stake_lim_reg <= pdr_pkg::LIMIT_RST;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                pdr_pkg::REG_SPACING:   spacing_reg   <= pwdata[15:0];
                pdr_pkg::REG_TIMESPAN:  timespan_reg  <= pwdata[23:0];
                pdr_pkg::REG_WORK_LIM:  work_lim_reg  <= pwdata;
                pdr_pkg::REG_STAKE_LIM: stake_lim_reg <= pwdata;
                default:                spacing_reg   <= spacing_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pdr_pkg::REG_SPACING:   prdata = 32'(spacing_reg);
            pdr_pkg::REG_TIMESPAN:  prdata = 32'(timespan_reg);
            pdr_pkg::REG_WORK_LIM:  prdata = work_lim_reg;
            pdr_pkg::REG_STAKE_LIM: prdata = stake_lim_reg;
            default:                prdata = '0;
        endcase
    end

    // Whole chain advances unless a finished beat is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    pdr_front #(.W(W)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (in_valid),
        .history_ready    (history_ready),
        .stake_mode       (stake_mode),
        .new_block_time   (new_block_time),
        .last_block_time  (last_block_time),
        .first_block_time (first_block_time),
        .last_target_word (last_target_word),
        .target_spacing   (spacing_reg),
        .target_timespan  (timespan_reg),
        .work_limit_word  (work_lim_reg),
        .stake_limit_word (stake_lim_reg),
        .out_valid        (mul_valid[0]),
        .out_ctl          (mul_ctl[0]),
        .out_span         (mul_span[0]),
        .out_t            (front_t),
        .lim_blen         (lim_blen)
    );

    assign mul_vec[0]   = (NL*32)'(front_t);
    assign mul_carry[0] = '0;

    // Multiply chain: one cell per limb
    for (genvar k = 0; k < NL; k++)
    begin : g_mul
        pdr_mul_cell #(.NL(NL), .K(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (mul_valid[k]),
            .in_ctl    (mul_ctl[k]),
            .in_span   (mul_span[k]),
            .in_vec    (mul_vec[k]),
            .in_carry  (mul_carry[k]),
            .out_valid (mul_valid[k+1]),
            .out_ctl   (mul_ctl[k+1]),
            .out_span  (mul_span[k+1]),
            .out_vec   (mul_vec[k+1]),
            .out_carry (mul_carry[k+1])
        );
    end

    assign div_valid[0] = mul_valid[NL];
    assign div_ctl[0]   = mul_ctl[NL];
    assign div_vec[0]   = mul_vec[NL][W-1:0];
    assign div_rem[0]   = '0;

    // Divide chain: one cell per quotient bit
    for (genvar j = 0; j < W; j++)
    begin : g_div
        pdr_div_cell #(.W(W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (timespan_reg),
            .in_valid  (div_valid[j]),
            .in_ctl    (div_ctl[j]),
            .in_vec    (div_vec[j]),
            .in_rem    (div_rem[j]),
            .out_valid (div_valid[j+1]),
            .out_ctl   (div_ctl[j+1]),
            .out_vec   (div_vec[j+1]),
            .out_rem   (div_rem[j+1])
        );
    end

    pdr_back #(.W(W)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (div_valid[W]),
        .in_ctl           (div_ctl[W]),
        .in_q             (div_vec[W]),
        .target_timespan  (timespan_reg),
        .work_limit_word  (work_lim_reg),
        .lim_blen         (lim_blen),
        .out_valid        (out_valid),
        .next_target_word (next_target_word),
        .rule_taken       (rule_taken)
    );

endmodule
